// ===== src/y422_pkg.sv =====
// Package: shared types, constants and register indexes for the 4:2:0 to packed 4:2:2 converter.
`timescale 1ns / 1ps
package y422_pkg;

    localparam int MAX_PAIRS_DEF = 1024;
    localparam int MAX_ROWS_DEF  = 4096;
    localparam int QUEUE_DEPTH   = 4;

    localparam int BYTE_W   = 8;
    localparam int PAIR_W   = 10;
    localparam int ROW_W    = 12;
    localparam int PPR_W    = 11;
    localparam int RCNT_W   = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int CHROMA_W = 2 * BYTE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACKING_MODE  = 2'd0,
        CFG_PAIRS_PER_ROW = 2'd1,
        CFG_ROW_COUNT     = 2'd2,
        CFG_FLIP_ROWS     = 2'd3
    } t_cfg_idx;

    localparam logic PACK_YUYV = 1'b0;
    localparam logic PACK_UYVY = 1'b1;

    typedef struct packed {
        logic [PPR_W-1:0]  pairs_per_row;
        logic [RCNT_W-1:0] row_count;
        logic              flip_rows;
    } t_geom;

    typedef struct packed {
        logic [BYTE_W-1:0] y0;
        logic [BYTE_W-1:0] y1;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
        logic [ROW_W-1:0]  orow;
        logic [PAIR_W-1:0] col;
        logic              fend;
    } t_item;

endpackage

// ===== src/y422_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module y422_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/y422_front.sv =====
// Front end: position counters, row classification, chroma line buffer access.
`timescale 1ns / 1ps
module y422_front #(
    parameter int MAX_PAIRS = y422_pkg::MAX_PAIRS_DEF,
    parameter int MAX_ROWS  = y422_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  y422_pkg::t_geom                   i_geom,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [y422_pkg::IN_TDATA_W-1:0]   i_data,
    output logic                              o_push,
    input  logic                              i_q_ready,
    output y422_pkg::t_item                   o_item
);
    import y422_pkg::*;

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [12:0] MaxPairsW = 13'(MAX_PAIRS);
    localparam logic [13:0] MaxRowsW  = 14'(MAX_ROWS);

    logic [PAIR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_s1_valid;
    logic              r_s1_odd;
    t_item             r_s1;

    logic [12:0] pairs, pairs_m1, idx_w;
    logic [13:0] rows, rows_m1, row_x, orow_w;
    logic        last_pair, last_row, accept, advance, odd;
    logic [AW-1:0] idx;
    logic [CHROMA_W-1:0] rd_chroma;
    logic [BYTE_W-1:0] y0, y1, cb, cr;

    assign y0 = i_data[7:0];
    assign y1 = i_data[15:8];
    assign cb = i_data[23:16];
    assign cr = i_data[31:24];

    always_comb begin
        if (i_geom.pairs_per_row == '0) begin
            pairs = 13'd1;
        end else if ({2'b0, i_geom.pairs_per_row} > MaxPairsW) begin
            pairs = MaxPairsW;
        end else begin
            pairs = {2'b0, i_geom.pairs_per_row};
        end
        if (i_geom.row_count < 13'd2) begin
            rows = 14'd2;
        end else if ({1'b0, i_geom.row_count} > MaxRowsW) begin
            rows = MaxRowsW;
        end else begin
            rows = {1'b0, i_geom.row_count};
        end
    end

    assign pairs_m1  = pairs - 13'd1;
    assign rows_m1   = rows - 14'd1;
    assign row_x     = {2'b0, r_row};
    assign last_pair = {3'b0, r_col} >= pairs_m1;
    assign last_row  = row_x >= rows_m1;
    assign odd       = r_row[0];
    assign idx_w     = ({3'b0, r_col} < MaxPairsW) ? {3'b0, r_col} : (MaxPairsW - 13'd1);
    assign idx       = idx_w[AW-1:0];

    always_comb begin
        if (!i_geom.flip_rows) begin
            orow_w = row_x;
        end else if (row_x <= rows_m1) begin
            orow_w = rows_m1 - row_x;
        end else begin
            orow_w = '0;
        end
    end

    assign advance = r_s1_valid && i_q_ready;
    assign o_ready = !r_s1_valid || advance;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_pair) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    y422_ram #(
        .WIDTH (CHROMA_W),
        .DEPTH (MAX_PAIRS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && !odd),
        .i_waddr (idx),
        .i_wdata ({cr, cb}),
        .i_re    (accept && odd),
        .i_raddr (idx),
        .o_rdata (rd_chroma)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_odd  <= odd;
            r_s1.y0   <= y0;
            r_s1.y1   <= y1;
            r_s1.u    <= cb;
            r_s1.v    <= cr;
            r_s1.orow <= orow_w[ROW_W-1:0];
            r_s1.col  <= r_col;
            r_s1.fend <= last_pair && last_row;
        end
    end

    always_comb begin
        o_item = r_s1;
        if (r_s1_odd) begin
            o_item.u = rd_chroma[BYTE_W-1:0];
            o_item.v = rd_chroma[CHROMA_W-1:BYTE_W];
        end
    end

    assign o_push = advance;

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_q_ready |=> r_s1_valid && $stable(r_s1) && $stable(r_s1_odd))
        else $error("front stage changed while stalled");
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_pair |=> r_col == '0)
        else $error("pair counter did not wrap at end of row");
    a_odd_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_q_ready && r_s1_odd |=> $stable(rd_chroma))
        else $error("line buffer read data lost during stall");
`endif
endmodule

// ===== src/y422_queue.sv =====
// Short request queue between front end and packer.
`timescale 1ns / 1ps
module y422_queue #(
    parameter int DEPTH = y422_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  y422_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output y422_pkg::t_item o_item
);
    import y422_pkg::*;

    t_item         r_buf [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");
`endif
endmodule

// ===== src/y422_back.sv =====
// Back end: byte packing and output register.
`timescale 1ns / 1ps
module y422_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_mode,
    input  logic                               i_q_valid,
    input  y422_pkg::t_item                    i_item,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [y422_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tlast
);
    import y422_pkg::*;

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   r_last;
    logic [31:0]            word;

    always_comb begin
        if (i_mode == PACK_UYVY) begin
            word = {i_item.y1, i_item.v, i_item.y0, i_item.u};
        end else begin
            word = {i_item.v, i_item.y1, i_item.u, i_item.y0};
        end
    end

    assign o_pop = i_q_valid && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {2'b0, i_item.col, i_item.orow, word};
            r_last <= i_item.fend;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
endmodule

// ===== src/yv12_to_packed_422_top.sv =====
// Top level: planar 4:2:0 to packed 4:2:2 converter with configuration registers.
//
//  channel  dir  width  handshake                     contents
//  s        in   32     i_s_tvalid / o_s_tready       luma pair and Cb/Cr pair
//  m        out  56+1   o_m_tvalid / i_m_tready       packed word, position, tlast
//  cfg      in   2+13   i_cfg_we                      register writes
//
//  One request per cycle while i_m_tready is high; registers: front stage, queue, output.
//  Odd rows take chroma from a 1024 x 16 line buffer read at accept, valid the cycle after.
//  Synchronous active-low reset clears counters and valids; the line buffer is not cleared.
//  Input and output stall independently through a four-entry queue.
`timescale 1ns / 1ps
module yv12_to_packed_422_top #(
    parameter int MAX_PAIRS = y422_pkg::MAX_PAIRS_DEF,
    parameter int MAX_ROWS  = y422_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] luma_first, [15:8] luma_second, [23:16] chroma_blue, [31:24] chroma_red
    input  logic [y422_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] packed_word, [43:32] out_row, [53:44] out_pair, [55:54] zero
    output logic [y422_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic [y422_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [y422_pkg::CFG_W-1:0]        i_cfg_data
);
    import y422_pkg::*;

    logic              r_mode;
    t_geom             r_geom;
    logic              push, q_ready, q_valid, pop;
    t_item             f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode               <= PACK_YUYV;
            r_geom.pairs_per_row <= PPR_W'(1024);
            r_geom.row_count     <= RCNT_W'(480);
            r_geom.flip_rows     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PACKING_MODE:  r_mode               <= i_cfg_data[0];
                CFG_PAIRS_PER_ROW: r_geom.pairs_per_row <= i_cfg_data[PPR_W-1:0];
                CFG_ROW_COUNT:     r_geom.row_count     <= i_cfg_data[RCNT_W-1:0];
                CFG_FLIP_ROWS:     r_geom.flip_rows     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    y422_front #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_data    (i_s_tdata),
        .o_push    (push),
        .i_q_ready (q_ready),
        .o_item    (f_item)
    );

    y422_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    y422_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );
endmodule
